[src/isr_pkg.sv]
// ----------------------------------------------------------------------------
// isr_pkg
// shared types and constants for the image sample reduction block
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int SAMPLE_BITS_DEF      = 8;
    localparam int MAX_SAMPLES_LOG2_DEF = 22;
    localparam int MEAN_FRAC_BITS_DEF   = 8;

    localparam int MODE_BITS = 3;

    localparam logic [MODE_BITS-1:0] MODE_MIN      = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX      = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SUM      = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MEAN     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_DISTINCT = 3'd4;

    typedef enum logic [2:0]
    {
        ST_ACC,
        ST_LAST,
        ST_DIV,
        ST_HOLD,
        ST_CLEAR
    } state_t;

    typedef struct packed
    {
        logic start;
    } div_ctrl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[src/isr_divider.sv]
// ----------------------------------------------------------------------------
// isr_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module isr_divider #(
    parameter int NUM_BITS = 38,
    parameter int DEN_BITS = 23
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isr_pkg::div_ctrl_t     ctrl,
    input  logic [NUM_BITS-1:0]    dividend,
    input  logic [DEN_BITS-1:0]    divisor,
    output isr_pkg::div_status_t   status,
    output logic [NUM_BITS-1:0]    quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] rem_next;
    logic [NUM_BITS-1:0] quo_reg;
    logic [NUM_BITS-1:0] quo_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_BITS-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        quo_next = {quo_reg[NUM_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

[src/image_sample_reduction.sv]
// ----------------------------------------------------------------------------
// image_sample_reduction
// per-frame min, max, sum, mean and distinct count over a sample stream
// ----------------------------------------------------------------------------
// one sample beat accepted per cycle while a frame streams in
// result is captured in ST_LAST and loaded into the output register in ST_HOLD;
// for the mean the bit-serial divider runs in ST_DIV between the two, and
// ST_HOLD waits while the output register is full and not taken; input is held
// off from the last beat until the seen bitmap is cleared after the result is loaded
// reset clears all statistics and the mode register, then runs the same clear
// ----------------------------------------------------------------------------
module image_sample_reduction #(
    parameter int SAMPLE_BITS      = isr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES_LOG2 = isr_pkg::MAX_SAMPLES_LOG2_DEF,
    parameter int MEAN_FRAC_BITS   = isr_pkg::MEAN_FRAC_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  cfg_wr_en,
    input  logic [isr_pkg::MODE_BITS-1:0]                         cfg_wr_data,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                      s_tdata,
    input  logic                                                  s_tlast,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // value
    output logic [((SAMPLE_BITS+MAX_SAMPLES_LOG2+7)/8)*8-1:0]     m_tdata,
    // overflow
    output logic                                                  m_tuser
);

    localparam int VW     = SAMPLE_BITS + MAX_SAMPLES_LOG2;
    localparam int CW     = MAX_SAMPLES_LOG2 + 1;
    localparam int DW     = SAMPLE_BITS + 1;
    localparam int NW     = VW + MEAN_FRAC_BITS;
    localparam int LEVELS = 1 << SAMPLE_BITS;
    localparam int TDW    = ((VW + 7) / 8) * 8;

    isr_pkg::state_t state_reg;
    isr_pkg::state_t state_next;

    logic [isr_pkg::MODE_BITS-1:0] mode_reg;
    logic [SAMPLE_BITS-1:0]        min_reg;
    logic [SAMPLE_BITS-1:0]        max_reg;
    logic [VW-1:0]                 sum_reg;
    logic [CW-1:0]                 count_reg;
    logic [DW-1:0]                 distinct_reg;
    logic                          ovf_reg;
    logic [SAMPLE_BITS-1:0]        clr_addr_reg;
    logic [SAMPLE_BITS-1:0]        clr_addr_next;

    logic                          seen_mem [LEVELS];
    logic                          seen_rd_reg;
    logic                          pend_reg;
    logic                          fwd_reg;
    logic [SAMPLE_BITS-1:0]        smp_reg;

    logic [VW-1:0]                 res_reg;
    logic                          res_ovf_reg;
    logic [VW-1:0]                 out_value_reg;
    logic                          out_ovf_reg;
    logic                          out_valid_reg;

    logic [SAMPLE_BITS-1:0]        sample;
    logic                          accept;
    logic [SAMPLE_BITS-1:0]        min_next;
    logic [SAMPLE_BITS-1:0]        max_next;
    logic [VW-1:0]                 sum_next;
    logic [CW-1:0]                 count_next;
    logic [DW-1:0]                 distinct_next;
    logic [DW-1:0]                 distinct_fin;
    logic                          ovf_next;
    logic                          hit;
    logic [VW-1:0]                 sel_value;
    logic                          load_out;
    logic                          mem_we;
    logic [SAMPLE_BITS-1:0]        mem_waddr;
    logic                          mem_wdata;

    isr_pkg::div_ctrl_t            div_ctrl;
    isr_pkg::div_status_t          div_status;
    logic [NW-1:0]                 div_quotient;

    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready  = (state_reg == isr_pkg::ST_ACC);
    assign accept    = s_tvalid && s_tready;
    assign load_out  = (state_reg == isr_pkg::ST_HOLD) && (!out_valid_reg || m_tready);
    assign hit       = fwd_reg || seen_rd_reg;

    // seen bitmap, updated in the cycle after the accepted beat
    assign mem_we    = (state_reg == isr_pkg::ST_CLEAR) || pend_reg;
    assign mem_waddr = (state_reg == isr_pkg::ST_CLEAR) ? clr_addr_reg : smp_reg;
    assign mem_wdata = (state_reg != isr_pkg::ST_CLEAR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[mem_waddr] <= mem_wdata;
        end
        seen_rd_reg <= seen_mem[sample];
    end

    // statistics
    always_comb
    begin
        min_next      = min_reg;
        max_next      = max_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        distinct_fin  = distinct_reg + DW'(pend_reg && !hit);
        distinct_next = distinct_fin;
        if (accept)
        begin
            if (sample < min_reg)
            begin
                min_next = sample;
            end
            if (sample > max_reg)
            begin
                max_next = sample;
            end
            if (!count_reg[CW-1])
            begin
                sum_next   = sum_reg + VW'(sample);
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (state_reg == isr_pkg::ST_LAST)
        begin
            min_next      = '1;
            max_next      = '0;
            sum_next      = '0;
            count_next    = '0;
            distinct_next = '0;
            ovf_next      = 1'b0;
        end

        case (mode_reg)
            isr_pkg::MODE_MAX:      sel_value = VW'(max_reg);
            isr_pkg::MODE_SUM:      sel_value = sum_reg;
            isr_pkg::MODE_DISTINCT: sel_value = VW'(distinct_fin);
            default:                sel_value = VW'(min_reg);
        endcase
    end

    assign div_ctrl.start = (state_reg == isr_pkg::ST_LAST) && (mode_reg == isr_pkg::MODE_MEAN);

    isr_divider #(
        .NUM_BITS (NW),
        .DEN_BITS (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend ({sum_reg, {MEAN_FRAC_BITS{1'b0}}}),
        .divisor  (count_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            isr_pkg::ST_ACC:
            begin
                if (accept && s_tlast)
                begin
                    state_next = isr_pkg::ST_LAST;
                end
            end
            isr_pkg::ST_LAST:
            begin
                state_next = (mode_reg == isr_pkg::MODE_MEAN) ? isr_pkg::ST_DIV
                                                              : isr_pkg::ST_HOLD;
            end
            isr_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = isr_pkg::ST_HOLD;
                end
            end
            isr_pkg::ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = isr_pkg::ST_CLEAR;
                end
            end
            isr_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + SAMPLE_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_next = isr_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = isr_pkg::ST_ACC;
            end
        endcase
    end

    // frame accumulators, cleared in ST_LAST as the result is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= isr_pkg::MODE_MIN;
            min_reg      <= '1;
            max_reg      <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            distinct_reg <= '0;
            ovf_reg      <= 1'b0;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
            smp_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            min_reg      <= min_next;
            max_reg      <= max_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            distinct_reg <= distinct_next;
            ovf_reg      <= ovf_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= accept;
            // same value as the beat being written this cycle
            fwd_reg      <= pend_reg && (smp_reg == sample);
            if (accept)
            begin
                smp_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == isr_pkg::ST_LAST)
        begin
            res_reg     <= sel_value;
            res_ovf_reg <= ovf_reg;
        end
        else if (div_status.done)
        begin
            res_reg <= div_quotient[VW-1:0];
        end
        if (load_out)
        begin
            out_value_reg <= res_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_value_reg);
    assign m_tuser  = out_ovf_reg;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the image sample reduction block
// a directed table of short frames covers the sample extremes, every mode
// including the codes above four, and typed-in results where they are obvious.
// random frames follow, in phases with a fresh mode each, with random gaps on
// the sample stream and random back-pressure on the result stream. each
// result beat is checked against an in-bench model of the frame statistics.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SAMPLE_W      = isr_pkg::SAMPLE_BITS_DEF;
    localparam int COUNT_LOG2    = isr_pkg::MAX_SAMPLES_LOG2_DEF;
    localparam int FRAC_W        = isr_pkg::MEAN_FRAC_BITS_DEF;
    localparam int MODE_W        = isr_pkg::MODE_BITS;
    localparam int VALUE_W       = SAMPLE_W + COUNT_LOG2;
    localparam int IN_BUS_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BUS_W     = ((VALUE_W + 7) / 8) * 8;
    localparam int LEVELS        = 1 << SAMPLE_W;
    localparam longint COUNT_CAP = 64'd1 << COUNT_LOG2;

    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int SETTLE_CYCLES = SAMPLE_W + COUNT_LOG2 + FRAC_W + 20;
    localparam int HOLD_CYCLES   = 1000;
    localparam int HOLD_PHASE    = 2;
    localparam int RANDOM_ITEMS  = 360;
    localparam int DIR_ROWS      = 24;

    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } stat_beat_t;

    typedef struct packed
    {
        logic [MODE_W-1:0]    mode;
        logic [SAMPLE_W-1:0]  sample;
        logic                 last;
        logic                 typed;
        logic [VALUE_W-1:0]   value;
    } dir_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [MODE_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_BUS_W-1:0]   s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_BUS_W-1:0]  m_tdata;
    logic                  m_tuser;

    // frame statistics model
    logic [MODE_W-1:0]     cur_mode;
    logic [SAMPLE_W-1:0]   acc_min;
    logic [SAMPLE_W-1:0]   acc_max;
    logic [VALUE_W-1:0]    acc_sum;
    logic [COUNT_LOG2:0]   acc_count;
    bit                    seen_value [LEVELS];
    logic [SAMPLE_W:0]     acc_distinct;
    logic                  acc_ovf;

    stat_beat_t            pending_stats [$];
    int                    errors          = 0;
    int                    results_checked = 0;
    int                    frames_sent     = 0;
    int                    samples_sent    = 0;
    bit   [7:0]            modes_written   = '0;
    bit                    idle_on         = 1'b1;
    bit                    hold_req        = 1'b0;

    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{isr_pkg::MODE_MIN,      8'd255, 1'b1, 1'b1, 30'd255},
        '{isr_pkg::MODE_MIN,      8'd0,   1'b1, 1'b1, 30'd0},
        '{isr_pkg::MODE_MAX,      8'd0,   1'b1, 1'b1, 30'd0},
        '{isr_pkg::MODE_MAX,      8'd255, 1'b1, 1'b1, 30'd255},
        '{isr_pkg::MODE_SUM,      8'd255, 1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_SUM,      8'd255, 1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_SUM,      8'd255, 1'b1, 1'b1, 30'd765},
        '{isr_pkg::MODE_MEAN,     8'd255, 1'b1, 1'b1, 30'd65280},
        '{isr_pkg::MODE_MEAN,     8'd0,   1'b1, 1'b1, 30'd0},
        '{isr_pkg::MODE_MEAN,     8'd1,   1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_MEAN,     8'd2,   1'b1, 1'b0, 30'd0},
        '{isr_pkg::MODE_DISTINCT, 8'd7,   1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_DISTINCT, 8'd7,   1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_DISTINCT, 8'd200, 1'b1, 1'b1, 30'd2},
        '{MODE_RSVD5,             8'd9,   1'b0, 1'b0, 30'd0},
        '{MODE_RSVD5,             8'd3,   1'b1, 1'b1, 30'd3},
        '{MODE_RSVD6,             8'd100, 1'b1, 1'b1, 30'd100},
        '{MODE_RSVD7,             8'haa,  1'b0, 1'b0, 30'd0},
        '{MODE_RSVD7,             8'h55,  1'b1, 1'b1, 30'h55},
        '{isr_pkg::MODE_MEAN,     8'd10,  1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_MEAN,     8'd11,  1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_MEAN,     8'd13,  1'b1, 1'b0, 30'd0},
        '{isr_pkg::MODE_DISTINCT, 8'd0,   1'b0, 1'b0, 30'd0},
        '{isr_pkg::MODE_DISTINCT, 8'd255, 1'b1, 1'b1, 30'd2}
    };

    image_sample_reduction u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic clear_stats();
        acc_min      = '1;
        acc_max      = '0;
        acc_sum      = '0;
        acc_count    = '0;
        acc_distinct = '0;
        acc_ovf      = 1'b0;
        for (int i = 0; i < LEVELS; i++)
            seen_value[i] = 1'b0;
    endtask

    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                                 input logic typed, input logic [VALUE_W-1:0] typed_val);
        stat_beat_t   b;
        logic [63:0]  num;
        logic [63:0]  mean;
        if (s < acc_min)
            acc_min = s;
        if (s > acc_max)
            acc_max = s;
        if (64'(acc_count) < COUNT_CAP)
        begin
            acc_sum   = acc_sum + VALUE_W'(s);
            acc_count = acc_count + 1'b1;
        end
        else
            acc_ovf = 1'b1;
        if (!seen_value[s])
        begin
            seen_value[s] = 1'b1;
            acc_distinct  = acc_distinct + 1'b1;
        end
        if (l)
        begin
            num  = 64'(acc_sum) << FRAC_W;
            mean = (acc_count != 0) ? num / 64'(acc_count) : 64'd0;
            case (cur_mode)
                isr_pkg::MODE_MAX:      b.value = VALUE_W'(acc_max);
                isr_pkg::MODE_SUM:      b.value = acc_sum;
                isr_pkg::MODE_MEAN:     b.value = mean[VALUE_W-1:0];
                isr_pkg::MODE_DISTINCT: b.value = VALUE_W'(acc_distinct);
                default:                b.value = VALUE_W'(acc_min);
            endcase
            b.overflow = acc_ovf;
            if (typed)
                b.value = typed_val;
            pending_stats.push_back(b);
            frames_sent++;
            clear_stats();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
        errors++;
    endtask

    task automatic check_result(input logic [OUT_BUS_W-1:0] data, input logic ovf);
        stat_beat_t e;
        if (pending_stats.size() == 0)
            flag_mismatch("result beat with nothing pending", 64'(data), 64'd0);
        else
        begin
            e = pending_stats.pop_front();
            if (data !== OUT_BUS_W'(e.value))
                flag_mismatch("value", 64'(data), 64'(e.value));
            if (ovf !== e.overflow)
                flag_mismatch("overflow", 64'(ovf), 64'(e.overflow));
            results_checked++;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        else if (r < 96)
            return $urandom_range(9, 40);
        else
            return $urandom_range(100, 200);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return SAMPLE_W'($urandom_range(0, LEVELS - 1));
        else if (r < 7)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return SAMPLE_W'($urandom_range(120, 123));
    endfunction

    task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic l,
                             input logic typed, input logic [VALUE_W-1:0] typed_val);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BUS_W'(s);
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_sample(s, l, typed, typed_val);
        samples_sent++;
    endtask

    task automatic idle_gap();
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_mode     = m;
        modes_written[m] = 1'b1;
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0]  frame_buf [LEVELS];
        logic [SAMPLE_W-1:0]  tmp;
        logic [MODE_W-1:0]    m;
        int                   random_sent;
        int                   phase;
        int                   nframes;
        int                   len;
        int                   j;

        cur_mode = isr_pkg::MODE_MIN;
        clear_stats();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == 0 || dir_table[i-1].last)
                set_mode(dir_table[i].mode);
            send_beat(dir_table[i].sample, dir_table[i].last,
                      dir_table[i].typed, dir_table[i].value);
            idle_gap();
        end

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            m = (phase < 8) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 7));
            idle_on = (phase == 2 || phase == 5 || phase == 9) ? 1'b0
                                                                : ($urandom_range(0, 3) != 0);
            set_mode(m);
            // long result hold while the stream keeps coming
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            nframes = (phase == HOLD_PHASE) ? 6 : $urandom_range(1, 4);
            for (int f = 0; f < nframes && random_sent < RANDOM_ITEMS; f++)
            begin
                if (phase == isr_pkg::MODE_DISTINCT && f == 0)
                begin
                    // every level once, shuffled
                    len = LEVELS;
                    for (int k = 0; k < LEVELS; k++)
                        frame_buf[k] = SAMPLE_W'(k);
                    for (int k = LEVELS - 1; k > 0; k--)
                    begin
                        j            = $urandom_range(0, k);
                        tmp          = frame_buf[k];
                        frame_buf[k] = frame_buf[j];
                        frame_buf[j] = tmp;
                    end
                end
                else
                begin
                    len = pick_len();
                    if (len > RANDOM_ITEMS - random_sent)
                        len = RANDOM_ITEMS - random_sent;
                    for (int k = 0; k < len; k++)
                        frame_buf[k] = pick_sample();
                end
                for (int k = 0; k < len; k++)
                begin
                    send_beat(frame_buf[k], k == len - 1, 1'b0, '0);
                    idle_gap();
                end
                random_sent += len;
            end
            phase++;
        end

        wait_drained();
        $display("covered %0d frames, %0d sample beats, %0d result beats checked",
                 frames_sent, samples_sent, results_checked);
        $display("mode codes written (bit per code): %b, %0d random phases",
                 modes_written, phase);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
src/isr_pkg.sv
src/isr_divider.sv
src/image_sample_reduction.sv
tb/testbench.sv
